@@ sv/assert_macros.svh @@
// Assertion macros used by the equaliser RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ sv/lsze_pkg.sv @@
`timescale 1ns / 1ps
// Types and constants for the LS channel estimate / ZF equaliser.
// No dependencies.
package lsze_pkg;
  typedef enum logic [1:0] {
    OP_COEF = 2'd0,
    OP_PILOT = 2'd1,
    OP_EQ = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_ROUND,
    ST_POWER,
    ST_DIV,
    ST_OUT
  } state_t;

  localparam int DivQBits = 17;
endpackage

@@ sv/lsze_divider.sv @@
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, for both eq parts at once.
// Depends on lsze_pkg.
module lsze_divider #(
  parameter int NumW = 34,
  parameter int DenW = 33,
  parameter int QW = 17
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [NumW-1:0] num_a,
  input  logic [NumW-1:0] num_b,
  input  logic [DenW-1:0] den,
  output logic            done,
  output logic [QW-1:0]   quo_a,
  output logic [QW-1:0]   quo_b
);
  import lsze_pkg::*;
  localparam int RW = DenW + 2;
  localparam int CW = $clog2(NumW + 1);

  logic [NumW-1:0] na_r, nb_r;
  logic [RW-1:0]   ra_r, rb_r;
  logic [DenW:0]   d2_r;
  logic [CW-1:0]   cnt_r;
  logic            busy_r;
  logic [QW-1:0]   qa_r, qb_r;
  logic [RW-1:0]   ta, tb;

  assign ta = {ra_r[RW-2:0], na_r[NumW-1]};
  assign tb = {rb_r[RW-2:0], nb_r[NumW-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NumW);
        na_r   <= num_a;
        nb_r   <= num_b;
        ra_r   <= '0;
        rb_r   <= '0;
        qa_r   <= '0;
        qb_r   <= '0;
        d2_r   <= {den, 1'b0};
      end else if (busy_r) begin
        na_r <= na_r << 1;
        nb_r <= nb_r << 1;
        if (ta >= RW'(d2_r)) begin
          ra_r <= ta - RW'(d2_r);
          qa_r <= {qa_r[QW-2:0], 1'b1} | {QW{qa_r[QW-1]}};
        end else begin
          ra_r <= ta;
          qa_r <= {qa_r[QW-2:0], 1'b0} | {QW{qa_r[QW-1]}};
        end
        if (tb >= RW'(d2_r)) begin
          rb_r <= tb - RW'(d2_r);
          qb_r <= {qb_r[QW-2:0], 1'b1} | {QW{qb_r[QW-1]}};
        end else begin
          rb_r <= tb;
          qb_r <= {qb_r[QW-2:0], 1'b0} | {QW{qb_r[QW-1]}};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  assign quo_a = qa_r;
  assign quo_b = qb_r;
endmodule

@@ sv/ls_channel_estimate_zf_equalizer.sv @@
`timescale 1ns / 1ps
// LS channel estimate and zero-forcing equaliser, top level.
// Depends on lsze_pkg, lsze_divider and assert_macros.svh.
// Writes, unused opcodes and out-of-range equalise requests leave the block idle. An equalise
// transfer holds off further input until its result is loaded into the output register. The
// time goes on coefficient-memory reads and one pair of MACs per pilot, rounding, the products,
// a bit-serial divider producing one quotient bit per cycle and the output load. A zero
// denominator skips the divider. One item at a time; a finished result waits in the output
// register while the next item is accepted, and a result stalled behind it holds the input.
module ls_channel_estimate_zf_equalizer #(
  parameter int PILOT_COUNT = 32,
  parameter int SUBCARRIER_COUNT = 256,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [15:0]             cfg_regularization,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_opcode,
  input  logic [13:0]             in_address,
  input  logic signed [SAMPLE_WIDTH-1:0] in_value_re,
  input  logic signed [SAMPLE_WIDTH-1:0] in_value_im,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [7:0]              out_subcarrier,
  output logic signed [SAMPLE_WIDTH-1:0] out_eq_re,
  output logic signed [SAMPLE_WIDTH-1:0] out_eq_im,
  output logic                    out_saturated
);
  import lsze_pkg::*;
  `include "assert_macros.svh"

  localparam int W = SAMPLE_WIDTH;
  localparam int ColCount = 2 * SUBCARRIER_COUNT;
  localparam int Depth = PILOT_COUNT * ColCount;
  localparam int AW = $clog2(Depth);
  localparam int PW = (PILOT_COUNT > 1) ? $clog2(PILOT_COUNT) : 1;
  localparam int SW = (SUBCARRIER_COUNT > 1) ? $clog2(SUBCARRIER_COUNT) : 1;
  localparam int PCW = $clog2(PILOT_COUNT + 1);
  localparam int AccW = 2 * W + PCW + 1;
  localparam int InFrac = W - 2;
  localparam int OutFrac = W - 5;
  localparam int ProdW = 2 * W + 1;
  localparam int DenW = 2 * W + 1;
  localparam int NumW = ProdW + OutFrac + 2;
  localparam int QW = W + 1;
  localparam logic signed [W-1:0] SMax = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] SMin = {1'b1, {(W-1){1'b0}}};

  logic signed [W-1:0] coef_mem [Depth];
  logic signed [W-1:0] pilot_mem [PILOT_COUNT];
  logic signed [W-1:0] coef_re_r, coef_im_r, pilot_r;

  state_t state_r, state_nxt;
  logic [15:0] reg_r;
  logic [PCW-1:0] rd_cnt_r;
  logic rd_valid_r;
  logic [SW-1:0] sc_r;
  logic signed [W-1:0] vre_r, vim_r;
  logic signed [AccW-1:0] acc_re_r, acc_im_r;
  logic signed [W-1:0] hre_r, him_r;
  logic sat_r;
  logic signed [2*W+1:0] pwr_r;
  logic signed [ProdW-1:0] nre_r, nim_r;
  logic den_zero;
  logic div_start, div_done;
  logic [QW-1:0] qa, qb;
  logic [NumW-1:0] mag_a, mag_b;
  logic ovalid_r;
  logic accept_in;
  logic out_load;
  logic wait_r;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) reg_r <= 16'd1;
    else if (cfg_valid) reg_r <= cfg_regularization;
  end

  assign in_ready = (state_r == ST_IDLE);
  assign accept_in = in_valid && in_ready;

  logic [AW-1:0] rd_addr_re, rd_addr_im;
  assign rd_addr_re = AW'(rd_cnt_r[PW-1:0] * ColCount + sc_r);
  assign rd_addr_im = AW'(rd_cnt_r[PW-1:0] * ColCount + SUBCARRIER_COUNT + sc_r);

  // memory: one write port, read port per column half
  always_ff @(posedge clk) begin
    if (accept_in && in_opcode == OP_COEF && int'(in_address) < Depth)
      coef_mem[AW'(in_address)] <= in_value_re;
    if (accept_in && in_opcode == OP_PILOT && in_address < 14'(PILOT_COUNT))
      pilot_mem[in_address[PW-1:0]] <= in_value_re;
    coef_re_r <= coef_mem[rd_addr_re];
    coef_im_r <= coef_mem[rd_addr_im];
    pilot_r   <= pilot_mem[rd_cnt_r[PW-1:0]];
  end

  function automatic logic signed [W-1:0] round_h(input logic signed [AccW-1:0] a,
                                                 output logic s);
    logic signed [AccW-1:0] t;
    t = (a + (AccW'(1) <<< (InFrac - 1))) >>> InFrac;
    s = 1'b0;
    if (t > AccW'(SMax)) begin s = 1'b1; return SMax; end
    if (t < AccW'(SMin)) begin s = 1'b1; return SMin; end
    return t[W-1:0];
  endfunction

  logic s1, s2;
  logic signed [W-1:0] rh_re, rh_im;
  always_comb begin
    rh_re = round_h(acc_re_r, s1);
    rh_im = round_h(acc_im_r, s2);
  end

  assign den_zero = (pwr_r == '0);
  assign mag_a = nre_r[ProdW-1] ? NumW'(-nre_r) << (OutFrac + 1) : NumW'(nre_r) << (OutFrac + 1);
  assign mag_b = nim_r[ProdW-1] ? NumW'(-nim_r) << (OutFrac + 1) : NumW'(nim_r) << (OutFrac + 1);

  // (mag*2^(f+1) + d) / 2d == floor(mag*2^f/d + 1/2): feed mag*2^(f+1)+d via extra half step
  logic [NumW-1:0] na_in, nb_in;
  assign na_in = mag_a + NumW'(pwr_r);
  assign nb_in = mag_b + NumW'(pwr_r);
  assign div_start = (state_r == ST_POWER) && !wait_r && !den_zero;

  lsze_divider #(.NumW(NumW), .DenW(DenW), .QW(QW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .num_a(na_in), .num_b(nb_in), .den(pwr_r[DenW-1:0]),
    .done(div_done), .quo_a(qa), .quo_b(qb)
  );

  function automatic logic signed [W-1:0] sign_clip(input logic [QW-1:0] q, input logic neg,
                                                    output logic s);
    logic [QW-1:0] qc;
    qc = (q > QW'(SMax) + 1'b1) ? QW'(SMax) + 1'b1 : q;
    s = 1'b0;
    if (neg) return W'(-qc);
    if (qc > QW'(SMax)) begin s = 1'b1; return SMax; end
    return qc[W-1:0];
  endfunction

  logic s3, s4;
  logic signed [W-1:0] ea, eb;
  always_comb begin
    ea = sign_clip(qa, nre_r[ProdW-1], s3);
    eb = sign_clip(qb, nim_r[ProdW-1], s4);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept_in && in_opcode == OP_EQ && in_address < 14'(SUBCARRIER_COUNT))
                 state_nxt = ST_MAC;
      ST_MAC: if (rd_valid_r && rd_cnt_r == PCW'(PILOT_COUNT)) state_nxt = ST_ROUND;
      ST_ROUND: state_nxt = ST_POWER;
      ST_POWER: if (!wait_r) state_nxt = den_zero ? ST_OUT : ST_DIV;
      ST_DIV: if (div_done) state_nxt = ST_OUT;
      ST_OUT: if (!ovalid_r || out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_load = (state_r == ST_OUT) && (!ovalid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
      rd_cnt_r <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (out_load) ovalid_r <= 1'b1;
      else if (out_ready) ovalid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          sc_r <= in_address[SW-1:0];
          vre_r <= in_value_re;
          vim_r <= in_value_im;
          rd_cnt_r <= '0;
          rd_valid_r <= 1'b0;
          acc_re_r <= '0;
          acc_im_r <= '0;
        end
        ST_MAC: begin
          if (rd_cnt_r != PCW'(PILOT_COUNT)) rd_cnt_r <= rd_cnt_r + 1'b1;
          rd_valid_r <= 1'b1;
          if (rd_valid_r) begin
            acc_re_r <= acc_re_r + AccW'(pilot_r * coef_re_r);
            acc_im_r <= acc_im_r + AccW'(pilot_r * coef_im_r);
          end
        end
        ST_ROUND: begin
          hre_r <= rh_re;
          him_r <= rh_im;
          sat_r <= s1 | s2;
        end
        ST_POWER: ;
        ST_DIV: ;
        ST_OUT: if (out_load) begin
          out_subcarrier <= 8'(sc_r);
          if (den_zero) begin
            out_eq_re <= '0;
            out_eq_im <= '0;
            out_saturated <= 1'b1;
          end else begin
            out_eq_re <= ea;
            out_eq_im <= eb;
            out_saturated <= sat_r | s3 | s4;
          end
        end
        default: ;
      endcase
    end
  end

  // products registered while wait_r is set in ST_POWER, used once it clears
  logic signed [2*W-1:0] p_rr, p_ii, p_vr, p_wi, p_wr, p_vi;
  always_ff @(posedge clk) begin
    p_rr <= hre_r * hre_r;
    p_ii <= him_r * him_r;
    p_vr <= vre_r * hre_r;
    p_wi <= vim_r * him_r;
    p_wr <= vim_r * hre_r;
    p_vi <= vre_r * him_r;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) wait_r <= 1'b0;
    else wait_r <= (state_r == ST_ROUND);
  end
  always_comb begin
    pwr_r = (2*W+2)'(p_rr) + (2*W+2)'(p_ii) + (2*W+2)'(reg_r);
    nre_r = ProdW'(p_vr) + ProdW'(p_wi);
    nim_r = ProdW'(p_wr) - ProdW'(p_vi);
  end

  assign out_valid = ovalid_r;

  `ASSERT_IMPL(a_ready_idle, clk, rst_n, in_ready, state_r == ST_IDLE)
  `ASSERT_NEXT(a_div_done, clk, rst_n, div_done, state_r == ST_OUT)
  `ASSERT_NEXT(a_wait, clk, rst_n, state_r == ST_ROUND, state_r == ST_POWER && wait_r)
endmodule
